[sv/itt_pkg.sv]
// Shared types and constants of the interval timer table.
package itt_pkg;

	localparam int ID_W = 16;
	localparam int TIME_W = 32;
	localparam int RESULT_LIMIT = 8;
	localparam int FIRE_W = 4;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_QUERY = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] start;
		logic              once;
	} entry_t;

	// shift: each live cell below the tail takes its upper neighbor; wrap: tail
	// takes wb, else the head entry is dropped; app: cell at fill level takes wb
	typedef struct packed {
		logic   shift;
		logic   wrap;
		logic   app;
		entry_t wb;
	} cell_ctl_t;

	typedef struct packed {
		logic            ok;
		logic            fired;
		logic [ID_W-1:0] id;
		logic            last;
	} result_t;

endpackage

[sv/itt_cell.sv]
// One timer slot of the rotating table.
module itt_cell #(
	parameter int SLOTS = 8,
	parameter int INDEX = 0
) (
	input  logic                        clk,
	input  itt_pkg::cell_ctl_t          ctl,
	input  logic [$clog2(SLOTS+1)-1:0]  len,
	input  itt_pkg::entry_t             nxt,
	output itt_pkg::entry_t             cur
);

	localparam int LW = $clog2(SLOTS + 1);

	itt_pkg::entry_t entry_q;
	logic            below_tail;
	logic            is_tail;
	logic            is_free;

	assign below_tail = LW'(INDEX + 1) < len;
	assign is_tail    = LW'(INDEX + 1) == len;
	assign is_free    = LW'(INDEX) == len;
	assign cur        = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			if (below_tail) begin
				entry_q <= nxt;
			end else if (is_tail && ctl.wrap) begin
				entry_q <= ctl.wb;
			end
		end else if (ctl.app && is_free) begin
			entry_q <= ctl.wb;
		end
	end

endmodule

[sv/itt_ctrl.sv]
// Sequencer that rotates the table past the head cell and builds the results.
module itt_ctrl #(
	parameter int SLOTS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  itt_pkg::op_t                      in_op,
	input  logic [itt_pkg::ID_W-1:0]          in_id,
	input  logic [itt_pkg::TIME_W-1:0]        in_period,
	input  logic [itt_pkg::TIME_W-1:0]        in_offset,
	input  logic                              in_once,
	input  logic [itt_pkg::TIME_W-1:0]        in_now,
	input  itt_pkg::entry_t                   head,
	output itt_pkg::cell_ctl_t                cell_ctl,
	output logic [$clog2(SLOTS+1)-1:0]        count,
	input  logic                              can_emit,
	output logic                              push,
	output itt_pkg::result_t                  res
);

	localparam int LW = $clog2(SLOTS + 1);

	itt_pkg::state_t                 state_q, state_d;
	itt_pkg::op_t                    op_q;
	logic [LW-1:0]                   len_q;
	logic [LW-1:0]                   rem_q;
	logic                            found_q;
	logic                            stop_q;
	logic [itt_pkg::FIRE_W-1:0]      nfired_q;
	logic                            pend_valid_q;
	logic                            pend_ok_q;
	logic [itt_pkg::ID_W-1:0]        pend_id_q;
	logic                            res_ok_q;
	logic [itt_pkg::ID_W-1:0]        id_q;
	logic [itt_pkg::TIME_W-1:0]      now_q;
	itt_pkg::entry_t                 new_q;

	logic                            accept;
	logic                            clear_all;
	logic [itt_pkg::TIME_W-1:0]      elapsed;
	logic                            head_exp;
	logic                            head_match;
	logic                            active;
	logic                            fire;
	logic                            stall;
	logic                            step;
	logic                            append;
	logic                            drop;

	assign in_ready   = state_q == itt_pkg::ST_IDLE;
	assign accept     = in_valid && in_ready;
	assign clear_all  = in_op == itt_pkg::OP_CLEAR && in_id == '0;
	assign count      = len_q;

	assign elapsed    = now_q - head.start;
	assign head_exp   = elapsed >= head.period;
	assign head_match = head.id == id_q;
	assign active     = state_q == itt_pkg::ST_SCAN && rem_q != '0;
	assign fire       = active && op_q == itt_pkg::OP_TICK && !stop_q && head_exp;
	// a new expiry pushes the held one out, which needs room at the output
	assign stall      = fire && pend_valid_q && !can_emit;
	assign step       = active && !stall;
	assign append     = state_q == itt_pkg::ST_SCAN && rem_q == '0 &&
	                    op_q == itt_pkg::OP_SET && !found_q && len_q < LW'(SLOTS);
	assign drop       = cell_ctl.shift && !cell_ctl.wrap;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			itt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = clear_all ? itt_pkg::ST_FINISH : itt_pkg::ST_SCAN;
				end
			end
			itt_pkg::ST_SCAN: begin
				if (rem_q == '0) begin
					state_d = itt_pkg::ST_FINISH;
				end
			end
			itt_pkg::ST_FINISH: begin
				if (can_emit) begin
					state_d = itt_pkg::ST_IDLE;
				end
			end
			default: state_d = itt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cell_ctl       = '0;
		cell_ctl.shift = step;
		cell_ctl.wrap  = 1'b1;
		cell_ctl.app   = append;
		cell_ctl.wb    = append ? new_q : head;
		if (step) begin
			case (op_q)
				itt_pkg::OP_SET: begin
					if (!found_q && head_match) begin
						cell_ctl.wb = new_q;
					end
				end
				itt_pkg::OP_CLEAR: begin
					if (!found_q && head_match) begin
						cell_ctl.wrap = 1'b0;
					end
				end
				itt_pkg::OP_TICK: begin
					if (fire) begin
						if (head.once) begin
							cell_ctl.wrap = 1'b0;
						end else begin
							cell_ctl.wb.start = now_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		push = 1'b0;
		res  = '0;
		unique case (state_q)
			itt_pkg::ST_SCAN: begin
				push      = fire && pend_valid_q && can_emit;
				res.ok    = pend_ok_q;
				res.fired = 1'b1;
				res.id    = pend_id_q;
			end
			itt_pkg::ST_FINISH: begin
				push     = can_emit;
				res.last = 1'b1;
				if (op_q == itt_pkg::OP_TICK) begin
					if (pend_valid_q) begin
						res.ok    = pend_ok_q;
						res.fired = 1'b1;
						res.id    = pend_id_q;
					end
				end else begin
					res.ok = res_ok_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= itt_pkg::ST_IDLE;
			op_q         <= itt_pkg::OP_SET;
			len_q        <= '0;
			rem_q        <= '0;
			found_q      <= 1'b0;
			stop_q       <= 1'b0;
			nfired_q     <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q         <= in_op;
				rem_q        <= len_q;
				found_q      <= 1'b0;
				stop_q       <= 1'b0;
				nfired_q     <= '0;
				pend_valid_q <= 1'b0;
				if (clear_all) begin
					len_q <= '0;
				end
			end else if (step) begin
				rem_q <= rem_q - 1'b1;
				if (drop) begin
					len_q <= len_q - 1'b1;
				end
				if (head_match && op_q != itt_pkg::OP_TICK) begin
					found_q <= 1'b1;
				end
				if (fire) begin
					pend_valid_q <= 1'b1;
					nfired_q     <= nfired_q + 1'b1;
					if (head_match || nfired_q == itt_pkg::FIRE_W'(itt_pkg::RESULT_LIMIT - 1)) begin
						stop_q <= 1'b1;
					end
				end
			end else if (append) begin
				len_q <= len_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q       <= in_id;
			now_q      <= in_now;
			new_q.id   <= in_id;
			new_q.period <= in_period;
			new_q.once <= in_once;
			new_q.start <= (in_offset != '0) ? in_now - in_period + in_offset : in_now;
			res_ok_q   <= len_q != '0;
		end else if (state_q == itt_pkg::ST_SCAN && rem_q == '0) begin
			res_ok_q <= found_q || append;
		end
		if (step && fire) begin
			pend_ok_q <= head_match;
			pend_id_q <= head.id;
		end
	end

endmodule

[sv/interval_timer_table.sv]
// Interval timer table: top level with the cell row and the output register.
//
// Input channel s_*: one item per operation (set, clear, query, tick), the
// operation code in s_tuser, the operands and the time sample in s_tdata.
// Output channel m_*: one result per set, clear or query; a tick gives one
// result per expired timer (up to eight), m_tlast on the final one, and a
// single non-fired result when nothing expired.
// The table is a row of SLOTS cells that rotates through the head cell one
// slot per cycle unless stalled; removals compact the row as it rotates.
// After acceptance an item passes the scan state, which rotates every live
// entry past the head cell, and then the finish state, which loads its final
// result before the return to idle; a clear of all ids skips the scan.
// A stalled receiver holds the registered result and freezes the rotation
// whenever another fired timer has to leave; s_tready stays low meanwhile.
// Reset empties the table at once; slot contents are not cleared and are
// only read below the fill count.
module interval_timer_table #(
	parameter int SLOTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,  // event_id, interval_ms, offset_ms, one_shot, now_ms
	input  logic [1:0]   s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,  // ok, fired_id
	output logic [0:0]   m_tuser,  // fired
	output logic         m_tlast
);

	localparam int LW = $clog2(SLOTS + 1);

	itt_pkg::entry_t    row [SLOTS];
	itt_pkg::cell_ctl_t cell_ctl;
	logic [LW-1:0]      count;
	logic               can_emit;
	logic               push;
	itt_pkg::result_t   res;
	itt_pkg::result_t   out_q;
	logic               out_valid_q;

	itt_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (itt_pkg::op_t'(s_tuser)),
		.in_id    (s_tdata[15:0]),
		.in_period(s_tdata[47:16]),
		.in_offset(s_tdata[79:48]),
		.in_once  (s_tdata[80]),
		.in_now   (s_tdata[112:81]),
		.head     (row[0]),
		.cell_ctl (cell_ctl),
		.count    (count),
		.can_emit (can_emit),
		.push     (push),
		.res      (res)
	);

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		itt_pkg::entry_t nxt;
		if (k == SLOTS - 1) begin : g_end
			assign nxt = cell_ctl.wb;
		end else begin : g_mid
			assign nxt = row[k+1];
		end
		itt_cell #(
			.SLOTS(SLOTS),
			.INDEX(k)
		) u_cell (
			.clk(clk),
			.ctl(cell_ctl),
			.len(count),
			.nxt(nxt),
			.cur(row[k])
		);
	end

	assign can_emit = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.id, out_q.ok};
	assign m_tuser  = out_q.fired;
	assign m_tlast  = out_q.last;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= LW'(SLOTS))
		else $error("table fill count beyond slot count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again right after an item");

	a_idle_table_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && !s_tvalid) |=> $stable(count))
		else $error("table changed without an item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !push)
		else $error("result loaded over a stalled one");
`endif

endmodule
